/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/ssd_pkg.sv */
// Types, constants and the segment table of the seven-segment driver.
`timescale 1ns / 1ps

package ssd_pkg;

    typedef enum logic [1:0] {
        MODE_INT    = 2'd0,
        MODE_HUND   = 2'd1,
        MODE_SIGN   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    localparam logic [1:0] DIGIT_A = 2'd0;
    localparam logic [1:0] DIGIT_B = 2'd1;
    localparam logic [1:0] DIGIT_C = 2'd2;
    localparam logic [1:0] DIGIT_D = 2'd3;

    localparam logic [6:0] SEG_MIDDLE = 7'h40;

    // Reciprocals for constant division: floor(x * R >> S).
    // 10000: underestimates by at most one, fixed by one compare-subtract.
    localparam logic [12:0] RECIP_10K  = 13'd6710;   // >> 26
    // Below 10000 these are exact.
    localparam logic [15:0] RECIP_10   = 16'd52429;  // >> 19
    localparam logic [12:0] RECIP_100  = 13'd5243;   // >> 19
    localparam logic [13:0] RECIP_1000 = 14'd8389;   // >> 23

    typedef struct packed {
        mode_t       mode;
        logic        negative;
        logic [13:0] value;     // magnitude mod 10000
    } rem_t;

    typedef struct packed {
        logic [3:0][6:0] segs;  // index 0 is digit D (units)
        logic            dp;    // decimal point on digit B
        logic [1:0]      first; // first digit index to send
    } disp_t;

    function automatic logic [6:0] seg_encode(input logic [3:0] digit);
        logic [6:0] segs;
        case (digit)
            4'd0:    segs = 7'h3F;
            4'd1:    segs = 7'h06;
            4'd2:    segs = 7'h5B;
            4'd3:    segs = 7'h4F;
            4'd4:    segs = 7'h66;
            4'd5:    segs = 7'h6D;
            4'd6:    segs = 7'h7D;
            4'd7:    segs = 7'h07;
            4'd8:    segs = 7'h7F;
            4'd9:    segs = 7'h67;
            default: segs = 7'h00;
        endcase
        return segs;
    endfunction

endpackage

/* hdl/ssd_in_if.sv */
// Input channel: mode, signed value and sign flag with valid/ready.
`timescale 1ns / 1ps

interface ssd_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [17:0] value;
    logic               negative;

    modport source (output valid, mode, value, negative, input ready);
    modport sink   (input valid, mode, value, negative, output ready);
endinterface

/* hdl/ssd_out_if.sv */
// Output channel: one displayed digit per transfer with valid/ready.
`timescale 1ns / 1ps

interface ssd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] digit_select;
    logic [6:0] segments;
    logic       decimal_point;
    logic       last;

    modport source (output valid, digit_select, segments, decimal_point, last, input ready);
    modport sink   (input valid, digit_select, segments, decimal_point, last, output ready);
endinterface

/* hdl/ssd_mod10k.sv */
// Stages 1-3: magnitude, quotient by 10000, remainder mod 10000.
`timescale 1ns / 1ps

module ssd_mod10k (
    input  logic         clk,
    input  logic         rst_n,
    ssd_in_if.sink       item,
    output logic         rem_valid,
    input  logic         rem_ready,
    output ssd_pkg::rem_t rem
);
    import ssd_pkg::*;

    logic        s1_valid_reg;
    mode_t       s1_mode_reg;
    logic        s1_neg_reg;
    logic [17:0] s1_mag_reg;

    logic        s2_valid_reg;
    mode_t       s2_mode_reg;
    logic        s2_neg_reg;
    logic [17:0] s2_mag_reg;
    logic [3:0]  s2_quot_reg;

    logic        s3_valid_reg;
    rem_t        s3_rem_reg;

    logic        en1, en2, en3;
    logic [17:0] mag_next;
    logic [30:0] quot_prod;
    logic [3:0]  quot_next;
    logic [17:0] diff;
    logic [17:0] rem_wide;
    rem_t        rem_next;

    assign en3 = !s3_valid_reg || rem_ready;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign item.ready = en1;

    // -131072 negates to 0x20000, correct as an unsigned magnitude
    assign mag_next = item.value[17] ? (~item.value + 18'd1) : item.value;

    assign quot_prod = {13'd0, s1_mag_reg} * {18'd0, RECIP_10K};
    assign quot_next = quot_prod[29:26];

    assign diff     = s2_mag_reg - ({14'd0, s2_quot_reg} * 18'd10000);
    assign rem_wide = (diff >= 18'd10000) ? (diff - 18'd10000) : diff;

    always_comb
    begin
        rem_next.mode     = s2_mode_reg;
        rem_next.negative = s2_neg_reg;
        rem_next.value    = rem_wide[13:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            // unused mode is taken and dropped here
            if (en1)
                s1_valid_reg <= item.valid && (mode_t'(item.mode) != MODE_UNUSED);
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_mode_reg <= mode_t'(item.mode);
            s1_neg_reg  <= item.negative;
            s1_mag_reg  <= mag_next;
        end
        if (en2)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_quot_reg <= quot_next;
        end
        if (en3)
            s3_rem_reg <= rem_next;
    end

    assign rem_valid = s3_valid_reg;
    assign rem       = s3_rem_reg;

endmodule

/* hdl/ssd_digits.sv */
// Stages 4-5: decimal digits of the remainder and segment encoding.
`timescale 1ns / 1ps

module ssd_digits (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rem_valid,
    output logic           rem_ready,
    input  ssd_pkg::rem_t  rem,
    output logic           disp_valid,
    input  logic           disp_ready,
    output ssd_pkg::disp_t disp
);
    import ssd_pkg::*;

    logic        s4_valid_reg;
    mode_t       s4_mode_reg;
    logic        s4_neg_reg;
    logic [13:0] s4_rem_reg;
    logic [9:0]  s4_tens_reg;   // rem / 10
    logic [6:0]  s4_hund_reg;   // rem / 100
    logic [3:0]  s4_thou_reg;   // rem / 1000

    logic        s5_valid_reg;
    disp_t       s5_disp_reg;

    logic        en4, en5;
    logic [29:0] tens_prod;
    logic [26:0] hund_prod;
    logic [27:0] thou_prod;
    logic [13:0] d0_wide;
    logic [9:0]  d1_wide;
    logic [6:0]  d2_wide;
    disp_t       disp_next;

    assign en5 = !s5_valid_reg || disp_ready;
    assign en4 = !s4_valid_reg || en5;
    assign rem_ready = en4;

    assign tens_prod = {16'd0, rem.value} * {14'd0, RECIP_10};
    assign hund_prod = {13'd0, rem.value} * {14'd0, RECIP_100};
    assign thou_prod = {14'd0, rem.value} * {14'd0, RECIP_1000};

    // digit = quotient - 10 * next quotient, 10x as two shifts
    assign d0_wide = s4_rem_reg - {1'b0, s4_tens_reg, 3'b0} - {3'b0, s4_tens_reg, 1'b0};
    assign d1_wide = s4_tens_reg - {s4_hund_reg, 3'b0} - {2'b0, s4_hund_reg, 1'b0};
    assign d2_wide = s4_hund_reg - {s4_thou_reg, 3'b0} - {2'b0, s4_thou_reg, 1'b0};

    always_comb
    begin
        disp_next = '0;
        if (s4_mode_reg == MODE_SIGN)
        begin
            // single result on digit A
            disp_next.segs[3] = s4_neg_reg ? SEG_MIDDLE : 7'h00;
            disp_next.first   = 2'd3;
        end
        else
        begin
            disp_next.segs[0] = seg_encode(d0_wide[3:0]);
            disp_next.segs[1] = seg_encode(d1_wide[3:0]);
            disp_next.segs[2] = seg_encode(d2_wide[3:0]);
            disp_next.segs[3] = seg_encode(s4_thou_reg);
            disp_next.dp      = (s4_mode_reg == MODE_HUND);
            disp_next.first   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en4)
                s4_valid_reg <= rem_valid;
            if (en5)
                s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_mode_reg <= rem.mode;
            s4_neg_reg  <= rem.negative;
            s4_rem_reg  <= rem.value;
            s4_tens_reg <= tens_prod[28:19];
            s4_hund_reg <= hund_prod[25:19];
            s4_thou_reg <= thou_prod[26:23];
        end
        if (en5)
            s5_disp_reg <= disp_next;
    end

    assign disp_valid = s5_valid_reg;
    assign disp       = s5_disp_reg;

endmodule

/* hdl/ssd_serializer.sv */
// Output stage: sends the digits of one item, one per transfer.
`timescale 1ns / 1ps

module ssd_serializer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           disp_valid,
    output logic           disp_ready,
    input  ssd_pkg::disp_t disp,
    ssd_out_if.source      result
);
    import ssd_pkg::*;

    logic            valid_reg;
    logic [1:0]      cnt_reg;
    logic [3:0][6:0] segs_reg;
    logic            dp_reg;

    logic            is_last;
    logic            take;
    logic            give;

    assign is_last    = (cnt_reg == 2'd3);
    assign give       = valid_reg && result.ready;
    assign disp_ready = !valid_reg || (result.ready && is_last);
    assign take       = disp_valid && disp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            if (disp_ready)
                valid_reg <= disp_valid;
            if (take)
                cnt_reg <= disp.first;
            else if (give)
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            segs_reg <= disp.segs;
            dp_reg   <= disp.dp;
        end
    end

    // count 0..3 walks digits D, C, B, A
    assign result.valid         = valid_reg;
    assign result.digit_select  = ~cnt_reg;
    assign result.segments      = segs_reg[cnt_reg];
    assign result.decimal_point = dp_reg && (~cnt_reg == DIGIT_B);
    assign result.last          = is_last;

endmodule

/* hdl/four_digit_seven_segment_driver.sv */
// Top level of the four-digit seven-segment driver.
//
// Channel item takes a mode, an 18-bit signed value and a sign flag.
// Channel result gives one digit per transfer: digit_select, segments,
// decimal_point and last (set on the final digit of an item).
// Integer and hundredths modes send digits D, C, B, A of the magnitude
// mod 10000; hundredths lights the decimal point on digit B. Sign mode
// sends one digit A with the middle segment set from the sign flag.
// Mode 3 is taken and produces nothing.
// Pipeline: an item passes six register stages (magnitude, quotient,
// remainder, digit quotients, segment encode, output register) before its
// first digit is offered; then one digit per cycle while result is ready.
// The serializer sends one digit per transfer and takes the next item
// as the final digit of the current one is sent.
// A stall on result holds the serializer; the pipeline stages fill behind
// it and item.ready drops only when every stage is full. Nothing is lost
// or repeated. Reset clears all valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module four_digit_seven_segment_driver (
    input  logic      clk,
    input  logic      rst_n,
    ssd_in_if.sink    item,
    ssd_out_if.source result
);
    import ssd_pkg::*;

    // remainder stream between stage 3 and stage 4
    logic  rem_valid;
    logic  rem_ready;
    rem_t  rem;

    // encoded display stream into the serializer
    logic  disp_valid;
    logic  disp_ready;
    disp_t disp;

    // result views for the checks below
    logic       mid_xfer;   // transfer of a digit that is not the last
    logic [1:0] out_sel;
    logic [1:0] sel_down;   // select expected on the following digit

    ssd_mod10k u_mod10k (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .rem_valid (rem_valid),
        .rem_ready (rem_ready),
        .rem       (rem)
    );

    ssd_digits u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .rem_valid  (rem_valid),
        .rem_ready  (rem_ready),
        .rem        (rem),
        .disp_valid (disp_valid),
        .disp_ready (disp_ready),
        .disp       (disp)
    );

    ssd_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .disp_valid (disp_valid),
        .disp_ready (disp_ready),
        .disp       (disp),
        .result     (result)
    );

    assign mid_xfer = result.valid && result.ready && !result.last;
    assign out_sel  = result.digit_select;
    assign sel_down = result.digit_select - 2'd1;

    // final digit of every item is digit A
    `ASSERT_IMPLIES(a_last_on_a, clk, rst_n, result.valid && result.last, out_sel == DIGIT_A)
    // decimal point only ever on digit B
    `ASSERT_IMPLIES(a_dp_on_b, clk, rst_n, result.valid && result.decimal_point, out_sel == DIGIT_B)
    // digits of an item follow back to back, D down to A
    `ASSERT_NEXT(a_no_gap, clk, rst_n, mid_xfer, result.valid)
    `ASSERT_NEXT(a_digit_order, clk, rst_n, mid_xfer, out_sel == $past(sel_down))

endmodule
